// ===== rtl/ilu_pkg.sv =====
`timescale 1ns / 1ps

package ilu_pkg;

    // iteration limits and tolerance
    localparam int MAX_ITER = 100;
    localparam int CONV_EPS = 1074;
    localparam int ITER_W   = $clog2(MAX_ITER + 2);

    // field and datapath widths
    localparam int PIX_W   = 25;
    localparam int FOC_W   = 24;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int Q_W     = 32;
    localparam int OPND_W  = 33;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 37;
    localparam int DIV_W   = 57;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic signed [OPND_W-1:0] CONV_EPS_S = OPND_W'(CONV_EPS);
    localparam logic [FOC_W-1:0] FOCAL_RESET = FOC_W'(4096);

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_FOCAL_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_PP      = 3'd2;
    localparam logic [IDX_W-1:0] REG_K1      = 3'd3;
    localparam logic [IDX_W-1:0] REG_K2      = 3'd4;
    localparam logic [IDX_W-1:0] REG_K3      = 3'd5;
    localparam logic [IDX_W-1:0] REG_P1      = 3'd6;
    localparam logic [IDX_W-1:0] REG_P2      = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NX_GO, ST_NX_WAIT, ST_NY_GO, ST_NY_WAIT,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
        ST_M9, ST_M10, ST_M11, ST_M12, ST_M13, ST_DIV_WAIT,
        ST_M14, ST_M15, ST_M16, ST_CHECK, ST_P1, ST_P2, ST_P3, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_XX, MUL_YY, MUL_XY, MUL_P2XX, MUL_P1YY, MUL_RK3,
        MUL_P1XY, MUL_RH, MUL_P2XY, MUL_P2R, MUL_P1R, MUL_EXI, MUL_EYI,
        MUL_XF, MUL_YF
    } mul_sel_t;

    typedef enum logic [4:0] {
        WB_NONE, WB_LOAD, WB_X0, WB_Y0, WB_XXF, WB_YYF, WB_XYR, WB_DX0,
        WB_DY0, WB_H2, WB_DXA29, WB_H1, WB_DYA29, WB_RAD, WB_DXA30,
        WB_DYA30_EX, WB_INV, WB_EY, WB_NX, WB_NY, WB_STEP, WB_OUTX, WB_OUTY
    } wb_sel_t;

    typedef enum logic [1:0] {
        DIV_NONE, DIV_X, DIV_Y, DIV_RECIP
    } div_sel_t;

    typedef struct packed {
        mul_sel_t mul;
        wb_sel_t  wb;
        div_sel_t div;
    } ilu_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic settled;
    } ilu_status_t;

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sd2147483647);
        lo = -PROD_W'(64'sd2147483648);
        if (v > hi)
            return Q_W'(hi);
        else if (v < lo)
            return Q_W'(lo);
        else
            return Q_W'(v);
    endfunction

    function automatic logic signed [PIX_W-1:0] sat25(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sd16777215);
        lo = -PROD_W'(64'sd16777216);
        if (v > hi)
            return PIX_W'(hi);
        else if (v < lo)
            return PIX_W'(lo);
        else
            return PIX_W'(v);
    endfunction

endpackage

// ===== rtl/ilu_divider.sv =====
`timescale 1ns / 1ps

module ilu_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          num_neg,
    input  logic [ilu_pkg::DIV_W-1:0]     num_mag,
    input  logic [ilu_pkg::Q_W-1:0]       den,
    output logic                          busy,
    output logic signed [ilu_pkg::Q_W-1:0] quot
);
    import ilu_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [Q_W:0]         rem_reg, rem_next;
    logic [Q_W-1:0]       den_reg;
    logic                 neg_reg, zero_reg, nz_reg;
    logic [Q_W:0]         rem_sh;
    logic                 ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh    = {rem_reg[Q_W-1:0], q_reg[DIV_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        rem_next  = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
        q_next    = {q_reg[DIV_W-2:0], ge};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= num_mag;
            rem_reg  <= '0;
            den_reg  <= den;
            neg_reg  <= num_neg;
            zero_reg <= (den == '0);
            nz_reg   <= (num_mag != '0);
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    // signed saturation of the magnitude quotient
    always_comb
    begin
        if (zero_reg)
            quot = !nz_reg ? '0 : (neg_reg ? {1'b1, {(Q_W-1){1'b0}}}
                                           : {1'b0, {(Q_W-1){1'b1}}});
        else if (neg_reg)
            quot = (q_reg > DIV_W'(64'h8000_0000)) ? {1'b1, {(Q_W-1){1'b0}}}
                                                  : Q_W'(-$signed({1'b0, q_reg[Q_W-1:0]}));
        else
            quot = (q_reg > DIV_W'(64'h7FFF_FFFF)) ? {1'b0, {(Q_W-1){1'b1}}}
                                                  : $signed(q_reg[Q_W-1:0]);
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/ilu_datapath.sv =====
`timescale 1ns / 1ps

module ilu_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ilu_pkg::ilu_cmd_t               cmd,
    output ilu_pkg::ilu_status_t            status,
    input  logic                            cfg_write,
    input  logic [ilu_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ilu_pkg::CFG_W-1:0]       cfg_data,
    input  logic signed [ilu_pkg::PIX_W-1:0] pixel_x,
    input  logic signed [ilu_pkg::PIX_W-1:0] pixel_y,
    output logic signed [ilu_pkg::PIX_W-1:0] corrected_x,
    output logic signed [ilu_pkg::PIX_W-1:0] corrected_y
);
    import ilu_pkg::*;

    logic [FOC_W-1:0]        focal_x_reg, focal_y_reg, cx_reg, cy_reg;
    logic signed [Q_W-1:0]   k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;

    logic signed [PIX_W-1:0] px_reg, py_reg, outx_reg, outy_reg;
    logic signed [Q_W-1:0]   x0_reg, y0_reg, x_reg, y_reg;
    logic signed [Q_W+1:0]   xxf_reg, yyf_reg;
    logic signed [Q_W-1:0]   xx_reg, yy_reg, xy_reg, h_reg, rad_reg, inv_reg;
    logic signed [Q_W-1:0]   ex_reg, ey_reg, nx_reg, ny_reg;
    logic signed [OPND_W-1:0] r_reg;
    logic signed [ACC_W-1:0] dx_reg, dy_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next, t28, t29, t30;
    logic signed [Q_W+2:0]   rsum;
    logic signed [OPND_W-1:0] r_next;

    logic                    div_start, div_neg, div_busy;
    logic [DIV_W-1:0]        div_mag;
    logic [Q_W-1:0]          div_den;
    logic signed [Q_W-1:0]   div_quot;
    logic signed [PIX_W:0]   off;
    logic [PIX_W:0]          off_mag;
    logic signed [OPND_W-1:0] dnx, dny;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg <= FOCAL_RESET;
            focal_y_reg <= FOCAL_RESET;
            cx_reg      <= '0;
            cy_reg      <= '0;
            k1_reg      <= '0;
            k2_reg      <= '0;
            k3_reg      <= '0;
            p1_reg      <= '0;
            p2_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOCAL_X: focal_x_reg <= cfg_data[FOC_W-1:0];
                REG_FOCAL_Y: focal_y_reg <= cfg_data[FOC_W-1:0];
                REG_PP:
                begin
                    cx_reg <= cfg_data[FOC_W-1:0];
                    cy_reg <= cfg_data[32+FOC_W-1:32];
                end
                REG_K1:      k1_reg <= cfg_data[Q_W-1:0];
                REG_K2:      k2_reg <= cfg_data[Q_W-1:0];
                REG_K3:      k3_reg <= cfg_data[Q_W-1:0];
                REG_P1:      p1_reg <= cfg_data[Q_W-1:0];
                REG_P2:      p2_reg <= cfg_data[Q_W-1:0];
                default:     ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_XX:   begin mul_a = OPND_W'(x_reg);  mul_b = OPND_W'(x_reg);  end
            MUL_YY:   begin mul_a = OPND_W'(y_reg);  mul_b = OPND_W'(y_reg);  end
            MUL_XY:   begin mul_a = OPND_W'(x_reg);  mul_b = OPND_W'(y_reg);  end
            MUL_P2XX: begin mul_a = OPND_W'(p2_reg); mul_b = OPND_W'(xx_reg); end
            MUL_P1YY: begin mul_a = OPND_W'(p1_reg); mul_b = OPND_W'(yy_reg); end
            MUL_RK3:  begin mul_a = r_reg;           mul_b = OPND_W'(k3_reg); end
            MUL_P1XY: begin mul_a = OPND_W'(p1_reg); mul_b = OPND_W'(xy_reg); end
            MUL_RH:   begin mul_a = r_reg;           mul_b = OPND_W'(h_reg);  end
            MUL_P2XY: begin mul_a = OPND_W'(p2_reg); mul_b = OPND_W'(xy_reg); end
            MUL_P2R:  begin mul_a = r_reg;           mul_b = OPND_W'(p2_reg); end
            MUL_P1R:  begin mul_a = r_reg;           mul_b = OPND_W'(p1_reg); end
            MUL_EXI:  begin mul_a = OPND_W'(ex_reg); mul_b = OPND_W'(inv_reg); end
            MUL_EYI:  begin mul_a = OPND_W'(ey_reg); mul_b = OPND_W'(inv_reg); end
            MUL_XF:   begin mul_a = OPND_W'(x_reg);  mul_b = $signed({9'd0, focal_x_reg}); end
            MUL_YF:   begin mul_a = OPND_W'(y_reg);  mul_b = $signed({9'd0, focal_y_reg}); end
            default:  ;
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign t28 = prod_reg >>> 28;
    assign t29 = prod_reg >>> 29;
    assign t30 = prod_reg >>> 30;

    // r = xx + yy clamped to [0, 2^32-1]; both parts are never negative
    assign rsum   = (Q_W+3)'(xxf_reg) + (Q_W+3)'(yyf_reg);
    assign r_next = (rsum > (Q_W+3)'(64'sh0_FFFF_FFFF)) ? OPND_W'(64'sh0_FFFF_FFFF)
                                                       : OPND_W'(rsum);

    // divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_neg   = 1'b0;
        div_mag   = '0;
        div_den   = '0;
        off       = '0;
        case (cmd.div)
            DIV_X:
            begin
                off = (PIX_W+1)'(px_reg) - $signed({2'b00, cx_reg});
                div_start = 1'b1;
                div_den   = Q_W'(focal_x_reg);
            end
            DIV_Y:
            begin
                off = (PIX_W+1)'(py_reg) - $signed({2'b00, cy_reg});
                div_start = 1'b1;
                div_den   = Q_W'(focal_y_reg);
            end
            DIV_RECIP:
            begin
                div_start = 1'b1;
                div_neg   = rad_reg < 0;
                div_mag   = DIV_W'(1) << (DIV_W - 1);
                div_den   = div_neg ? Q_W'(-(OPND_W'(rad_reg))) : Q_W'(rad_reg);
            end
            default: ;
        endcase
        off_mag = (off < 0) ? (PIX_W+1)'(-off) : (PIX_W+1)'(off);
        if (cmd.div == DIV_X || cmd.div == DIV_Y)
        begin
            div_neg = off < 0;
            div_mag = {1'b0, off_mag, 30'd0};
        end
    end

    ilu_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_neg (div_neg),
        .num_mag (div_mag),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd.wb)
            WB_LOAD:
            begin
                px_reg <= pixel_x;
                py_reg <= pixel_y;
            end
            WB_X0:
            begin
                x0_reg <= div_quot;
                x_reg  <= div_quot;
            end
            WB_Y0:
            begin
                y0_reg <= div_quot;
                y_reg  <= div_quot;
            end
            WB_XXF:
            begin
                xxf_reg <= (Q_W+2)'(t30);
                xx_reg  <= sat32(t30);
            end
            WB_YYF:
            begin
                yyf_reg <= (Q_W+2)'(t30);
                yy_reg  <= sat32(t30);
            end
            WB_XYR:
            begin
                xy_reg <= sat32(t30);
                r_reg  <= r_next;
            end
            WB_DX0:      dx_reg  <= ACC_W'(t29);
            WB_DY0:      dy_reg  <= ACC_W'(t29);
            WB_H2:       h_reg   <= sat32(PROD_W'(k2_reg) + t30);
            WB_DXA29:    dx_reg  <= dx_reg + ACC_W'(t29);
            WB_H1:       h_reg   <= sat32(PROD_W'(k1_reg) + t30);
            WB_DYA29:    dy_reg  <= dy_reg + ACC_W'(t29);
            WB_RAD:      rad_reg <= sat32(PROD_W'(64'sd268435456) + t30);
            WB_DXA30:    dx_reg  <= dx_reg + ACC_W'(t30);
            WB_DYA30_EX:
            begin
                dy_reg <= dy_reg + ACC_W'(t30);
                ex_reg <= sat32(PROD_W'(x0_reg) - PROD_W'(dx_reg));
            end
            WB_INV:      inv_reg <= div_quot;
            WB_EY:       ey_reg  <= sat32(PROD_W'(y0_reg) - PROD_W'(dy_reg));
            WB_NX:       nx_reg  <= sat32(t28);
            WB_NY:       ny_reg  <= sat32(t28);
            WB_STEP:
            begin
                x_reg <= nx_reg;
                y_reg <= ny_reg;
            end
            WB_OUTX:     outx_reg <= sat25(t30 + $signed({42'd0, cx_reg}));
            WB_OUTY:     outy_reg <= sat25(t30 + $signed({42'd0, cy_reg}));
            default:     ;
        endcase
    end

    assign dnx = OPND_W'(nx_reg) - OPND_W'(x_reg);
    assign dny = OPND_W'(ny_reg) - OPND_W'(y_reg);

    assign status.div_busy = div_busy;
    assign status.settled  = (dnx <= CONV_EPS_S) && (dnx >= -CONV_EPS_S) &&
                             (dny <= CONV_EPS_S) && (dny >= -CONV_EPS_S);

    assign corrected_x = outx_reg;
    assign corrected_y = outy_reg;

endmodule

// ===== rtl/ilu_ctrl.sv =====
`timescale 1ns / 1ps

module ilu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ilu_pkg::ilu_status_t status,
    output ilu_pkg::ilu_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output logic                 converged
);
    import ilu_pkg::*;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              conv_reg, conv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            conv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            conv_reg  <= conv_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        conv_next  = conv_reg;
        cmd.mul    = MUL_NONE;
        cmd.wb     = WB_NONE;
        cmd.div    = DIV_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.wb     = WB_LOAD;
                    iter_next  = '0;
                    state_next = ST_NX_GO;
                end
            end
            ST_NX_GO:
            begin
                cmd.div    = DIV_X;
                state_next = ST_NX_WAIT;
            end
            ST_NX_WAIT:
            begin
                cmd.wb = WB_X0;
                if (!status.div_busy)
                    state_next = ST_NY_GO;
            end
            ST_NY_GO:
            begin
                cmd.div    = DIV_Y;
                state_next = ST_NY_WAIT;
            end
            ST_NY_WAIT:
            begin
                cmd.wb = WB_Y0;
                if (!status.div_busy)
                    state_next = ST_M1;
            end
            ST_M1:  begin cmd.mul = MUL_XX;                        state_next = ST_M2;  end
            ST_M2:  begin cmd.mul = MUL_YY;   cmd.wb = WB_XXF;     state_next = ST_M3;  end
            ST_M3:  begin cmd.mul = MUL_XY;   cmd.wb = WB_YYF;     state_next = ST_M4;  end
            ST_M4:  begin cmd.mul = MUL_P2XX; cmd.wb = WB_XYR;     state_next = ST_M5;  end
            ST_M5:  begin cmd.mul = MUL_P1YY; cmd.wb = WB_DX0;     state_next = ST_M6;  end
            ST_M6:  begin cmd.mul = MUL_RK3;  cmd.wb = WB_DY0;     state_next = ST_M7;  end
            ST_M7:  begin cmd.mul = MUL_P1XY; cmd.wb = WB_H2;      state_next = ST_M8;  end
            ST_M8:  begin cmd.mul = MUL_RH;   cmd.wb = WB_DXA29;   state_next = ST_M9;  end
            ST_M9:  begin cmd.mul = MUL_P2XY; cmd.wb = WB_H1;      state_next = ST_M10; end
            ST_M10: begin cmd.mul = MUL_RH;   cmd.wb = WB_DYA29;   state_next = ST_M11; end
            ST_M11: begin cmd.mul = MUL_P2R;  cmd.wb = WB_RAD;     state_next = ST_M12; end
            ST_M12:
            begin
                cmd.mul    = MUL_P1R;
                cmd.wb     = WB_DXA30;
                cmd.div    = DIV_RECIP;
                state_next = ST_M13;
            end
            ST_M13: begin cmd.wb = WB_DYA30_EX; state_next = ST_DIV_WAIT; end
            ST_DIV_WAIT:
            begin
                cmd.wb = WB_INV;
                if (!status.div_busy)
                    state_next = ST_M14;
            end
            ST_M14: begin cmd.mul = MUL_EXI; cmd.wb = WB_EY; state_next = ST_M15; end
            ST_M15: begin cmd.mul = MUL_EYI; cmd.wb = WB_NX; state_next = ST_M16; end
            ST_M16: begin cmd.wb = WB_NY; state_next = ST_CHECK; end
            ST_CHECK:
            begin
                cmd.wb = WB_STEP;
                if (iter_reg > ITER_W'(MAX_ITER))
                begin
                    conv_next  = 1'b0;
                    state_next = ST_P1;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                    if (status.settled)
                    begin
                        conv_next  = 1'b1;
                        state_next = ST_P1;
                    end
                    else
                        state_next = ST_M1;
                end
            end
            ST_P1:   begin cmd.mul = MUL_XF;                    state_next = ST_P2;   end
            ST_P2:   begin cmd.mul = MUL_YF; cmd.wb = WB_OUTX;  state_next = ST_P3;   end
            ST_P3:   begin cmd.wb = WB_OUTY;                    state_next = ST_DONE; end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign converged = conv_reg;

endmodule

// ===== rtl/iterative_lens_undistort.sv =====
`timescale 1ns / 1ps
// an item runs n = 1 to 102 updates; each update is shared multiplier work plus a wait on the
// radix-2 divider; normalization adds two divider passes, and re-projection and the result
// beat follow the last update
// one item at a time: start is taken only while busy is low
// rst_n is asynchronous and active low; it clears the sequencer and restores register defaults
// the result beat is shown for one cycle on done; the receiver cannot stall it
module iterative_lens_undistort (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [ilu_pkg::PIX_W-1:0] pixel_x,
    input  logic signed [ilu_pkg::PIX_W-1:0] pixel_y,
    output logic                             done,
    output logic signed [ilu_pkg::PIX_W-1:0] corrected_x,
    output logic signed [ilu_pkg::PIX_W-1:0] corrected_y,
    output logic                             converged,
    input  logic                             cfg_write,
    input  logic [ilu_pkg::IDX_W-1:0]        cfg_index,
    input  logic [ilu_pkg::CFG_W-1:0]        cfg_data
);
    import ilu_pkg::*;

    // command and status between the sequencer and the arithmetic
    ilu_cmd_t    cmd;
    ilu_status_t status;

    // sequencer: normalization, update loop, iteration count, re-projection
    ilu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .converged (converged)
    );

    // datapath: config registers, one shared multiplier, one shared divider
    ilu_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .corrected_x (corrected_x),
        .corrected_y (corrected_y)
    );

endmodule

// ===== rtl/ilu_checker.sv =====
`timescale 1ns / 1ps

module ilu_protocol_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // result beat only while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done longer than one cycle");

    a_release: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy held after result beat");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

endmodule

bind iterative_lens_undistort ilu_protocol_checker u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
